@@ hdl/pdah_pkg.sv @@
// Package for the press detector: field widths, register indexes, reset values
// and the structures passed between the core and its averaging and detection modules.
// No dependencies.
package pdah_pkg;

    localparam int SAMPLE_W = 12;
    localparam int LEVEL_W = 12;
    localparam int DELTA_W = 13;
    localparam int SUM_W = 16;
    localparam int DIV_SHIFT = SUM_W + 4;

    localparam int THRESH_W = 12;
    localparam int HYST_W = 12;
    localparam int RUN_W = 8;
    localparam int WARM_W = 10;

    localparam int CFG_DATA_W = 12;
    localparam int CFG_INDEX_W = 3;

    localparam int WINDOW_DEF = 12;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESS_COUNT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE_COUNT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WARMUP_COUNT = 3'd4;

    localparam logic [THRESH_W-1:0] PRESS_THRESHOLD_RST = 12'd4095;
    localparam logic [HYST_W-1:0] HYSTERESIS_RST = 12'd200;
    localparam logic [RUN_W-1:0] PRESS_COUNT_RST = 8'd12;
    localparam logic [RUN_W-1:0] RELEASE_COUNT_RST = 8'd12;
    localparam logic [WARM_W-1:0] WARMUP_COUNT_RST = 10'd64;

    localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

    typedef struct packed {
        logic [THRESH_W-1:0] press_threshold;
        logic [HYST_W-1:0] hysteresis;
        logic [RUN_W-1:0] press_count;
        logic [RUN_W-1:0] release_count;
        logic [WARM_W-1:0] warmup_count;
    } cfg_t;

    typedef struct packed {
        logic valid;
        logic [LEVEL_W-1:0] level;
    } avg_word_t;

    typedef struct packed {
        logic valid;
        logic is_pressed;
        logic [LEVEL_W-1:0] level;
        logic [DELTA_W-1:0] level_delta;
    } result_word_t;

endpackage

@@ hdl/pdah_in_if.sv @@
// Input channel carrying one raw sensor word per handshake.
// Depends on pdah_pkg.
interface pdah_in_if;
    logic valid;
    logic ready;
    logic [pdah_pkg::SAMPLE_W-1:0] raw_sample;

    modport source (output valid, output raw_sample, input ready);
    modport sink (input valid, input raw_sample, output ready);
endinterface

@@ hdl/pdah_out_if.sv @@
// Output channel carrying one state-change word per handshake.
// Depends on pdah_pkg.
interface pdah_out_if;
    logic valid;
    logic ready;
    logic is_pressed;
    logic [pdah_pkg::LEVEL_W-1:0] level;
    logic signed [pdah_pkg::DELTA_W-1:0] level_delta;

    modport source (output valid, output is_pressed, output level, output level_delta,
                    input ready);
    modport sink (input valid, input is_pressed, input level, input level_delta,
                  output ready);
endinterface

@@ hdl/press_detector_average_hysteresis_core.sv @@
// Press detector: takes a raw force-sensor word each unstalled clock, averages it over a
// window of WINDOW samples held in a chain of cells. After warmup_count samples
// it reports each change between released and pressed as one word carrying the
// new state, the average and its difference from the previously reported average.
// A sample is accepted in every cycle that the result register is free or being
// emptied; its result, if any, is presented after passing through the running-sum
// register loaded at the accepting edge, the reciprocal multiplier, the division
// correction and the result register fed by the detector.
// Depends on pdah_pkg, pdah_in_if, pdah_out_if, pdah_avg and pdah_detect.
module press_detector_average_hysteresis_core #(
    parameter int WINDOW = pdah_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = pdah_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [pdah_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pdah_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    pdah_in_if.sink                            sample_ch,
    pdah_out_if.source                         result_ch
);
    import pdah_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    logic advance;
    avg_word_t avg;
    result_word_t result;

    logic out_valid_reg;
    logic out_valid_next;
    logic out_pressed_reg;
    logic out_pressed_next;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [LEVEL_W-1:0] out_level_next;
    logic [DELTA_W-1:0] out_delta_reg;
    logic [DELTA_W-1:0] out_delta_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_PRESS_THRESHOLD: cfg_next.press_threshold = cfg_wr_data[THRESH_W-1:0];
                REG_HYSTERESIS:      cfg_next.hysteresis = cfg_wr_data[HYST_W-1:0];
                REG_PRESS_COUNT:     cfg_next.press_count = cfg_wr_data[RUN_W-1:0];
                REG_RELEASE_COUNT:   cfg_next.release_count = cfg_wr_data[RUN_W-1:0];
                REG_WARMUP_COUNT:    cfg_next.warmup_count = cfg_wr_data[WARM_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    assign advance = !out_valid_reg || result_ch.ready;
    assign sample_ch.ready = advance;

    pdah_avg #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_avg (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (sample_ch.valid),
        .sample   (sample_ch.raw_sample[SAMPLE_BITS-1:0]),
        .avg      (avg)
    );

    pdah_detect u_detect (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .avg     (avg),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign out_valid_next = advance ? result.valid : out_valid_reg;
    assign out_pressed_next = advance ? result.is_pressed : out_pressed_reg;
    assign out_level_next = advance ? result.level : out_level_reg;
    assign out_delta_next = advance ? result.level_delta : out_delta_reg;

    assign result_ch.valid = out_valid_reg;
    assign result_ch.is_pressed = out_pressed_reg;
    assign result_ch.level = out_level_reg;
    assign result_ch.level_delta = out_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.press_threshold <= PRESS_THRESHOLD_RST;
            cfg_reg.hysteresis <= HYSTERESIS_RST;
            cfg_reg.press_count <= PRESS_COUNT_RST;
            cfg_reg.release_count <= RELEASE_COUNT_RST;
            cfg_reg.warmup_count <= WARMUP_COUNT_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_pressed_reg <= out_pressed_next;
        out_level_reg <= out_level_next;
        out_delta_reg <= out_delta_next;
    end

endmodule

@@ hdl/pdah_cell.sv @@
// One cell of the sample window: holds a sample and hands it on when shifted.
// No dependencies.
module pdah_cell #(
    parameter int WIDTH = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             shift_en,
    input  logic [WIDTH-1:0] d,
    output logic [WIDTH-1:0] q
);

    logic [WIDTH-1:0] data_reg;
    logic [WIDTH-1:0] data_next;

    assign data_next = shift_en ? d : data_reg;
    assign q = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

endmodule

@@ hdl/pdah_avg.sv @@
// Sample window built from a chain of cells, running sum and the division by
// the window length. Depends on pdah_pkg and pdah_cell.
module pdah_avg #(
    parameter int WINDOW = pdah_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = pdah_pkg::SAMPLE_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    advance,
    input  logic                    in_valid,
    input  logic [SAMPLE_BITS-1:0]  sample,
    output pdah_pkg::avg_word_t     avg
);
    import pdah_pkg::*;

    localparam int DIV_M_W = DIV_SHIFT + 1;
    localparam logic [DIV_M_W-1:0] DIV_M = DIV_M_W'((64'd1 << DIV_SHIFT) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

    logic shift_en;
    logic [SAMPLE_BITS-1:0] tap [WINDOW];

    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;
    logic s1_valid_reg;
    logic s1_valid_next;

    logic [SUM_W+DIV_M_W-1:0] prod;
    logic [SUM_W-1:0] q0_reg;
    logic [SUM_W-1:0] q0_next;
    logic [SUM_W-1:0] sum2_reg;
    logic [SUM_W-1:0] sum2_next;
    logic s2_valid_reg;
    logic s2_valid_next;

    logic [SUM_W-1:0] q0_times_w;
    logic [SUM_W-1:0] rem;
    logic [SUM_W-1:0] quotient;
    logic [LEVEL_W-1:0] level_reg;
    logic [LEVEL_W-1:0] level_next;
    logic s3_valid_reg;
    logic s3_valid_next;

    assign shift_en = in_valid && advance;

    genvar i;
    generate
        for (i = 0; i < WINDOW; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                pdah_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (sample),
                    .q        (tap[i])
                );
            end
            else
            begin : g_body
                pdah_cell #(.WIDTH(SAMPLE_BITS)) u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (shift_en),
                    .d        (tap[i-1]),
                    .q        (tap[i])
                );
            end
        end
    endgenerate

    assign sum_next = shift_en
        ? SUM_W'(sum_reg + SUM_W'(sample) - SUM_W'(tap[WINDOW-1]))
        : sum_reg;
    assign s1_valid_next = advance ? shift_en : s1_valid_reg;

    assign prod = (SUM_W+DIV_M_W)'(sum_reg) * (SUM_W+DIV_M_W)'(DIV_M);
    assign q0_next = advance ? prod[DIV_SHIFT +: SUM_W] : q0_reg;
    assign sum2_next = advance ? sum_reg : sum2_reg;
    assign s2_valid_next = advance ? s1_valid_reg : s2_valid_reg;

    // The reciprocal estimate is at most one short, so a single correction step finishes it.
    assign q0_times_w = SUM_W'(q0_reg * WIN_C);
    assign rem = sum2_reg - q0_times_w;
    assign quotient = (rem >= WIN_C) ? SUM_W'(q0_reg + SUM_W'(1)) : q0_reg;
    assign level_next = advance ? quotient[LEVEL_W-1:0] : level_reg;
    assign s3_valid_next = advance ? s2_valid_reg : s3_valid_reg;

    assign avg.valid = s3_valid_reg;
    assign avg.level = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg <= sum_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        sum2_reg <= sum2_next;
        level_reg <= level_next;
    end

endmodule

@@ hdl/pdah_detect.sv @@
// Warm-up counter, run counters and hysteresis state for the press decision.
// Depends on pdah_pkg.
module pdah_detect (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  pdah_pkg::avg_word_t      avg,
    input  pdah_pkg::cfg_t           cfg,
    output pdah_pkg::result_word_t   result
);
    import pdah_pkg::*;

    logic [WARM_W-1:0] warm_reg;
    logic [WARM_W-1:0] warm_next;
    logic pressed_reg;
    logic pressed_next;
    logic [RUN_W-1:0] high_run_reg;
    logic [RUN_W-1:0] high_run_next;
    logic [RUN_W-1:0] low_run_reg;
    logic [RUN_W-1:0] low_run_next;
    logic [LEVEL_W-1:0] last_level_reg;
    logic [LEVEL_W-1:0] last_level_next;

    logic step;
    logic change;
    logic [RUN_W-1:0] high_inc;
    logic [RUN_W-1:0] low_inc;
    logic is_high;
    logic is_low;

    assign step = avg.valid && advance;
    assign high_inc = (high_run_reg == RUN_MAX) ? high_run_reg : RUN_W'(high_run_reg + 1'b1);
    assign low_inc = (low_run_reg == RUN_MAX) ? low_run_reg : RUN_W'(low_run_reg + 1'b1);
    assign is_high = avg.level >= cfg.press_threshold;
    // Below threshold minus hysteresis, rearranged so that no negative value arises.
    assign is_low = (({1'b0, avg.level} + {1'b0, cfg.hysteresis})
                     < {1'b0, cfg.press_threshold});

    always_comb
    begin
        warm_next = warm_reg;
        pressed_next = pressed_reg;
        high_run_next = high_run_reg;
        low_run_next = low_run_reg;
        last_level_next = last_level_reg;
        change = 1'b0;
        if (avg.valid)
        begin
            if (warm_reg < cfg.warmup_count)
            begin
                warm_next = WARM_W'(warm_reg + 1'b1);
            end
            else if (!pressed_reg)
            begin
                if (is_high)
                begin
                    high_run_next = high_inc;
                    change = high_inc >= cfg.press_count;
                end
                else
                begin
                    high_run_next = '0;
                end
            end
            else
            begin
                if (is_low)
                begin
                    low_run_next = low_inc;
                    change = low_inc >= cfg.release_count;
                end
                else
                begin
                    low_run_next = '0;
                end
            end
            if (change)
            begin
                pressed_next = !pressed_reg;
                high_run_next = '0;
                low_run_next = '0;
                last_level_next = avg.level;
            end
        end
    end

    assign result.valid = avg.valid && change;
    assign result.is_pressed = !pressed_reg;
    assign result.level = avg.level;
    assign result.level_delta = DELTA_W'({1'b0, avg.level} - {1'b0, last_level_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
            pressed_reg <= 1'b0;
            high_run_reg <= '0;
            low_run_reg <= '0;
            last_level_reg <= '0;
        end
        else if (step)
        begin
            warm_reg <= warm_next;
            pressed_reg <= pressed_next;
            high_run_reg <= high_run_next;
            low_run_reg <= low_run_next;
            last_level_reg <= last_level_next;
        end
    end

endmodule

@@ tb/sv/press_detector_average_hysteresis_core_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for press_detector_average_hysteresis_core: drives sensor
// words and register writes, predicts every state-change word and checks each one.
// Depends on pdah_pkg, pdah_in_if, pdah_out_if and the core.
module press_detector_average_hysteresis_core_tb;
    import pdah_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_SAMPLES = 650;
    localparam int DRAIN_LIMIT = 4000;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE = '1;

    typedef struct packed {
        logic                 is_pressed;
        logic [LEVEL_W-1:0]   level;
        logic [DELTA_W-1:0]   level_delta;
    } press_change_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    pdah_in_if  sample_ch ();
    pdah_out_if result_ch ();

    press_detector_average_hysteresis_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .sample_ch   (sample_ch.sink),
        .result_ch   (result_ch.source)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [THRESH_W-1:0] cfg_threshold;
    logic [HYST_W-1:0]   cfg_hysteresis;
    logic [RUN_W-1:0]    cfg_press_n;
    logic [RUN_W-1:0]    cfg_release_n;
    logic [WARM_W-1:0]   cfg_warmup;

    logic [SAMPLE_W-1:0] ring [WINDOW_DEF];
    logic [3:0]          ring_pos;
    logic [SUM_W-1:0]    ring_sum;
    logic [WARM_W-1:0]   warm_seen;
    logic                pressed;
    logic [RUN_W-1:0]    high_run;
    logic [RUN_W-1:0]    low_run;
    logic [LEVEL_W-1:0]  last_level;

    press_change_t changes_due [$];
    press_change_t change_head;
    int            fail_count = 0;
    int            samples_sent = 0;
    int            burst_left = 0;
    int            gap_max = 0;

    function automatic void reset_model();
        cfg_threshold = PRESS_THRESHOLD_RST;
        cfg_hysteresis = HYSTERESIS_RST;
        cfg_press_n = PRESS_COUNT_RST;
        cfg_release_n = RELEASE_COUNT_RST;
        cfg_warmup = WARMUP_COUNT_RST;
        foreach (ring[i])
            ring[i] = '0;
        ring_pos = '0;
        ring_sum = '0;
        warm_seen = '0;
        pressed = 1'b0;
        high_run = '0;
        low_run = '0;
        last_level = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PRESS_THRESHOLD: cfg_threshold = data[THRESH_W-1:0];
            REG_HYSTERESIS:      cfg_hysteresis = data[HYST_W-1:0];
            REG_PRESS_COUNT:     cfg_press_n = data[RUN_W-1:0];
            REG_RELEASE_COUNT:   cfg_release_n = data[RUN_W-1:0];
            REG_WARMUP_COUNT:    cfg_warmup = data[WARM_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic int release_level();
        return int'(cfg_threshold) - int'(cfg_hysteresis);
    endfunction

    function automatic void predict_press_change(input logic [SAMPLE_W-1:0] s);
        logic [LEVEL_W-1:0] avg;
        logic               changed;
        press_change_t      ev;
        changed = 1'b0;
        ring_sum = ring_sum - SUM_W'(ring[ring_pos]) + SUM_W'(s);
        ring[ring_pos] = s;
        ring_pos = (ring_pos == WINDOW_DEF - 1) ? 4'd0 : ring_pos + 4'd1;
        avg = LEVEL_W'(ring_sum / WINDOW_DEF);
        if (warm_seen < cfg_warmup)
        begin
            warm_seen = warm_seen + 1'b1;
            return;
        end
        if (!pressed)
        begin
            if (avg >= cfg_threshold)
            begin
                if (high_run != RUN_MAX)
                    high_run = high_run + 1'b1;
                if (high_run >= cfg_press_n)
                begin
                    pressed = 1'b1;
                    changed = 1'b1;
                end
            end
            else
                high_run = '0;
        end
        else
        begin
            if (int'(avg) < release_level())
            begin
                if (low_run != RUN_MAX)
                    low_run = low_run + 1'b1;
                if (low_run >= cfg_release_n)
                begin
                    pressed = 1'b0;
                    changed = 1'b1;
                end
            end
            else
                low_run = '0;
        end
        if (changed)
        begin
            high_run = '0;
            low_run = '0;
            ev.is_pressed = pressed;
            ev.level = avg;
            ev.level_delta = {1'b0, avg} - {1'b0, last_level};
            last_level = avg;
            changes_due.push_back(ev);
        end
    endfunction

    // The receiver follows a repeating 16-bit ready pattern that is redrawn periodically.
    logic [15:0] stall_pattern = 16'hFFFF;
    int          stall_step = 0;

    always @(negedge clk)
    begin
        if (stall_step % 128 == 127)
            stall_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : 16'($urandom) | 16'h0001;
        result_ch.ready <= stall_pattern[stall_step % 16];
        stall_step <= stall_step + 1;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (changes_due.size() == 0)
            begin
                $error("unexpected word: is_pressed %0b level %0d level_delta %0d",
                       result_ch.is_pressed, result_ch.level, result_ch.level_delta);
                fail_count++;
            end
            else
            begin
                change_head = changes_due.pop_front();
                if (result_ch.is_pressed !== change_head.is_pressed)
                begin
                    $error("is_pressed: expected %0b, actual %0b",
                           change_head.is_pressed, result_ch.is_pressed);
                    fail_count++;
                end
                if (result_ch.level !== change_head.level)
                begin
                    $error("level: expected %0d, actual %0d",
                           change_head.level, result_ch.level);
                    fail_count++;
                end
                if (DELTA_W'(result_ch.level_delta) !== change_head.level_delta)
                begin
                    $error("level_delta: expected %0d, actual %0d",
                           $signed(change_head.level_delta), result_ch.level_delta);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0)
            begin
                @(negedge clk);
                sample_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        sample_ch.valid <= 1'b1;
        sample_ch.raw_sample <= s;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        predict_press_change(s);
        samples_sent++;
    endtask

    task automatic send_above(input int n);
        repeat (n) send_sample($urandom_range(cfg_threshold, FULL_SCALE));
    endtask

    // Where the release level is not positive no average can fall below it.
    task automatic send_below(input int n);
        int rl;
        rl = release_level();
        if (rl > 0)
            repeat (n) send_sample($urandom_range(0, rl - 1));
        else
            repeat (n) send_sample($urandom);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (changes_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        apply_reg(idx, data);
    endtask

    task automatic test_reset_values();
        gap_max = 3;
        repeat (WARMUP_COUNT_RST) send_sample($urandom);
        repeat (2 * WINDOW_DEF + 2) send_sample(FULL_SCALE);
        repeat (2 * WINDOW_DEF + 2) send_sample('0);
    endtask

    task automatic test_zero_counts_and_masking();
        wait_idle();
        gap_max = 0;
        write_reg(REG_PRESS_THRESHOLD, 12'd0);
        write_reg(REG_HYSTERESIS, 12'd0);
        write_reg(REG_PRESS_COUNT, 12'hF00);
        write_reg(REG_RELEASE_COUNT, 12'h100);
        write_reg(REG_WARMUP_COUNT, 12'hC00);
        send_sample('0);
        send_sample(FULL_SCALE);
        send_sample(12'hAAA);
        send_sample(12'h555);
        wait_idle();
        write_reg(REG_PRESS_THRESHOLD, FULL_SCALE);
        send_sample(12'h800);
        repeat (WINDOW_DEF) send_sample(FULL_SCALE);
        send_sample('0);
    endtask

    task automatic test_hysteresis_above_threshold();
        wait_idle();
        write_reg(REG_PRESS_THRESHOLD, 12'd100);
        write_reg(REG_HYSTERESIS, 12'hFFF);
        write_reg(REG_PRESS_COUNT, 12'd1);
        write_reg(REG_RELEASE_COUNT, 12'd1);
        write_reg(REG_WARMUP_COUNT + 3'd1, 12'd0);
        write_reg(REG_WARMUP_COUNT + 3'd2, 12'hFFF);
        write_reg(REG_WARMUP_COUNT + 3'd3, 12'h3FF);
        repeat (2) send_sample(FULL_SCALE);
        repeat (WINDOW_DEF) send_sample('0);
    endtask

    task automatic test_warmup_rewrite();
        wait_idle();
        gap_max = 5;
        write_reg(REG_WARMUP_COUNT, 12'h3FF);
        write_reg(REG_PRESS_THRESHOLD, 12'd2048);
        write_reg(REG_HYSTERESIS, 12'd100);
        write_reg(REG_PRESS_COUNT, 12'd2);
        write_reg(REG_RELEASE_COUNT, 12'd2);
        repeat (30) send_sample($urandom);
        wait_idle();
        write_reg(REG_WARMUP_COUNT, 12'd10);
        repeat (16) send_sample(FULL_SCALE);
        repeat (16) send_sample('0);
    endtask

    task automatic test_longest_runs();
        wait_idle();
        gap_max = 2;
        write_reg(REG_PRESS_THRESHOLD, 12'd1500);
        write_reg(REG_HYSTERESIS, 12'd300);
        write_reg(REG_PRESS_COUNT, 12'd255);
        write_reg(REG_RELEASE_COUNT, 12'd255);
        write_reg(REG_WARMUP_COUNT, 12'd0);
        if (pressed)
            send_below(WINDOW_DEF + 258);
        send_above(WINDOW_DEF + 258);
        send_below(WINDOW_DEF + 258);
    endtask

    task automatic pick_random_settings();
        int n;
        case ($urandom_range(0, 7))
            0: write_reg(REG_PRESS_THRESHOLD, 12'd0);
            1: write_reg(REG_PRESS_THRESHOLD, FULL_SCALE);
            default: write_reg(REG_PRESS_THRESHOLD, 12'($urandom_range(64, 4000)));
        endcase
        if ($urandom_range(0, 7) == 0)
            write_reg(REG_HYSTERESIS, 12'($urandom));
        else
            write_reg(REG_HYSTERESIS, 12'($urandom_range(0, 400)));
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
        write_reg(REG_PRESS_COUNT, {4'($urandom), 8'(n)});
        n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 10);
        write_reg(REG_RELEASE_COUNT, {4'($urandom), 8'(n)});
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 200) : 0;
        write_reg(REG_WARMUP_COUNT, {2'($urandom), 10'(n)});
        if ($urandom_range(0, 3) == 0)
            write_reg(REG_WARMUP_COUNT + 3'($urandom_range(1, 3)), 12'($urandom));
    endtask

    // Mostly complete press and release sequences, with broken runs and noise between.
    task automatic test_random_stream();
        int first;
        int kind;
        first = samples_sent;
        while (samples_sent - first < RANDOM_SAMPLES)
        begin
            wait_idle();
            pick_random_settings();
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 8;
            endcase
            repeat ($urandom_range(3, 8))
            begin
                kind = $urandom_range(0, 9);
                if (kind < 6)
                begin
                    if (!pressed)
                        send_above(cfg_press_n + WINDOW_DEF + $urandom_range(0, 4));
                    else
                        send_below(cfg_release_n + WINDOW_DEF + $urandom_range(0, 4));
                end
                else if (kind < 8)
                begin
                    if (!pressed)
                    begin
                        send_above($urandom_range(1, cfg_press_n + WINDOW_DEF));
                        repeat ($urandom_range(1, 3)) send_sample('0);
                    end
                    else
                    begin
                        send_below($urandom_range(1, cfg_release_n + WINDOW_DEF));
                        repeat ($urandom_range(1, 3)) send_sample(FULL_SCALE);
                    end
                end
                else
                    repeat ($urandom_range(1, 20)) send_sample($urandom);
            end
        end
    endtask

    initial
    begin
        int drain_wait;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wr_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.raw_sample = '0;
        reset_model();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_zero_counts_and_masking();
        test_hysteresis_above_threshold();
        test_warmup_rewrite();
        test_longest_runs();
        test_random_stream();

        @(negedge clk);
        sample_ch.valid <= 1'b0;
        drain_wait = 0;
        while (changes_due.size() != 0 && drain_wait < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain_wait++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (changes_due.size() != 0)
        begin
            $error("%0d state changes never reported", changes_due.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("press_detector_average_hysteresis_core_tb: clean");
        else
            $display("press_detector_average_hysteresis_core_tb: errors");
        $finish;
    end

    initial
    begin
        #400000;
        $display("press_detector_average_hysteresis_core_tb: errors");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/pdah_pkg.sv
hdl/pdah_in_if.sv
hdl/pdah_out_if.sv
hdl/pdah_cell.sv
hdl/pdah_avg.sv
hdl/pdah_detect.sv
hdl/press_detector_average_hysteresis_core.sv
tb/sv/press_detector_average_hysteresis_core_tb.sv
